FILE: rtl/speed_gauge_arc_smoother_defines.svh
// Assertion shorthands shared by the checkers.
`ifndef SPEED_GAUGE_ARC_SMOOTHER_DEFINES_SVH
`define SPEED_GAUGE_ARC_SMOOTHER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define SGA_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sga check failed");

// Next-cycle implication, quiet during reset.
`define SGA_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sga check failed");

// Next-cycle implication that also watches reset itself.
`define SGA_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sga check failed");

`endif

FILE: rtl/sga_pkg.sv
package sga_pkg;

  localparam int IN_W  = 168;
  localparam int OUT_W = 128;

  // Input beat, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] override_value;
    logic [15:0] average_kph10;
    logic [7:0]  clock_minute;
    logic [7:0]  clock_hour;
    logic [31:0] session_id;
    logic        units_miles;
    logic [31:0] odo_dist;
    logic [3:0]  valid_flags;
    logic [15:0] spd_kmh;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [5:0]  shown_minute;
    logic [4:0]  shown_hour;
    logic        clock_ok;
    logic        shows_miles;
    logic [19:0] odo_value;
    logic [1:0]  odo_status;
    logic        speed_ok;
    logic [13:0] avg_arc;
    logic [23:0] peak_rgb;
    logic [13:0] peak_arc;
    logic [23:0] arc_rgb;
    logic [13:0] arc_ratio;
  } out_beat_t;

  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_OVERRIDE = 2'd1;
  localparam logic [1:0] OP_RECORD   = 2'd2;

  localparam logic [1:0] ODO_SHOWN   = 2'd0;
  localparam logic [1:0] ODO_UNKNOWN = 2'd1;
  localparam logic [1:0] ODO_OVER    = 2'd2;

  localparam logic [13:0] RATIO_FULL = 14'd10000;
  localparam logic [13:0] AMBER_AT   = 14'd6000;
  localparam logic [13:0] RED_AT     = 14'd8500;
  localparam logic [14:0] AMBER_SPAN = 15'd6000;
  localparam logic [14:0] RED_SPAN   = 15'd2500;
  localparam logic [23:0] GREY_RGB   = 24'h65717C;
  localparam logic [23:0] BLUE_RGB   = 24'h38A8FF;
  localparam logic [23:0] AMBER_RGB  = 24'hFFB000;
  localparam logic [23:0] RED_RGB    = 24'hFF4040;
  localparam logic [31:0] ODO_LIMIT  = 32'd999999;
  localparam logic [13:0] AVG_SCALE  = 14'd1000;
  localparam logic [13:0] MILE_NUM   = 14'd15625;   // 1000000 / 64
  localparam logic [14:0] MILE_DEN   = 15'd25146;   // 1609344 / 64
  localparam logic [8:0]  MAX_LO     = 9'd20;
  localparam logic [8:0]  MAX_HI     = 9'd400;
  localparam logic [8:0]  MAX_DEF    = 9'd200;

  // Divider geometry: numerator bits and quotient bits per job.
  localparam int DIV_NW = 46;
  localparam logic [5:0] K_RATIO = 6'd22;
  localparam logic [5:0] K_AVG   = 6'd22;
  localparam logic [5:0] K_ODO   = 6'd46;
  localparam logic [5:0] K_CH    = 6'd21;

endpackage

FILE: rtl/speed_gauge_arc_smoother.sv
// A record or no-op beat goes from accept to the done step. An override runs bit-serial
// divides where needed for three colour channels, an update for glide, ratio, three
// colour channels, average and miles; each yields k quotient bits, k = 21..46 at the
// default GLIDE_MS. Throughput: one beat in flight, set by the shared one-bit-per-cycle
// divider; a full output register holds the block in its last step until out_tready.
// Reset (rst_n low, synchronous): gauge state back to its idle values, max speed 200.
module speed_gauge_arc_smoother #(
  parameter int GLIDE_MS = 250
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // tdata, low bit up: now_ms, speed, valid_flags, odometer, units_miles,
  // session id, clock_hour, clock_minute, average_kph10, override_value
  input  logic [sga_pkg::IN_W-1:0]   in_tdata,
  input  logic [1:0]                 in_tuser,   // operation
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // tdata, low bit up: arc_ratio, arc_rgb, peak arc, peak_rgb, average arc,
  // speed_ok, odo_status, odo_value, shows_miles, clock_ok, shown_hour, shown_minute
  output logic [sga_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wen,
  input  logic [8:0]                 cfg_wdata
);
  import sga_pkg::*;

  // elapsed time below GLIDE_MS fits in EW bits
  localparam int EW = $clog2(GLIDE_MS + 1);
  localparam logic [5:0] K_GLIDE = 6'(14 + EW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Job sequence for one beat.
  localparam logic [2:0] J_GLIDE = 3'd0;
  localparam logic [2:0] J_RATIO = 3'd1;
  localparam logic [2:0] J_AVG   = 3'd2;
  localparam logic [2:0] J_ODO   = 3'd3;
  localparam logic [2:0] J_CH0   = 3'd4;
  localparam logic [2:0] J_CH1   = 3'd5;
  localparam logic [2:0] J_CH2   = 3'd6;
  localparam logic [2:0] J_FIN   = 3'd7;

  logic [2:0]  st_r, job_r;
  logic [5:0]  cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [14:0] rem_r, den_r;
  logic        neg_r;
  in_beat_t    item_r;
  logic [1:0]  op_r;
  logic [8:0]  mx_r;

  // gauge state
  logic [13:0] arc_now_r, arc_start_r, arc_goal_r, peak_r, avg_r, blend_r;
  logic [31:0] move_r, gen_r;
  logic [23:0] colour_r, peak_col_r;
  logic        ovr_r, spd_ok_r, sess_r, clk_ok_r, miles_r;
  logic [1:0]  odo_st_r;
  logic [19:0] odo_val_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;

  logic [OUT_W-1:0] out_tdata_r;
  logic             out_tvalid_r;

  // ---------------------------------------------------------------- helpers
  in_beat_t    in_beat;
  logic [8:0]  mx;
  logic [31:0] elapsed;
  logic signed [14:0] gdiff;
  logic [13:0] gmag;
  logic        lower;
  logic [1:0]  ch;
  logic [23:0] col_a, col_b;
  logic [7:0]  ca, cb;
  logic signed [8:0] cdiff;
  logic [7:0]  cmag;
  logic [13:0] bt;
  logic [14:0] bspan;
  logic [31:0] mul_a;
  logic [13:0] mul_b;
  logic [45:0] prod;
  logic [5:0]  kbits;
  logic [14:0] den;
  logic [15:0] trial;
  logic        ge;
  logic [2:0]  after_blend;
  logic [15:0] ovr_clamp;
  out_beat_t   ob;

  assign in_beat = in_beat_t'(in_tdata);
  assign mx = (mx_r >= MAX_LO && mx_r <= MAX_HI) ? mx_r : MAX_DEF;
  assign elapsed = item_r.now_ms - move_r;
  assign gdiff = $signed({1'b0, arc_goal_r}) - $signed({1'b0, arc_start_r});
  assign gmag  = gdiff[14] ? 14'(-gdiff) : gdiff[13:0];

  // Colour blend: two-segment ramp, one channel per divide.
  assign lower = blend_r < AMBER_AT;
  assign ch    = job_r[1:0];
  assign col_a = lower ? BLUE_RGB  : AMBER_RGB;
  assign col_b = lower ? AMBER_RGB : RED_RGB;
  assign ca    = 8'(col_a >> {ch, 3'b000});
  assign cb    = 8'(col_b >> {ch, 3'b000});
  assign cdiff = $signed({1'b0, cb}) - $signed({1'b0, ca});
  assign cmag  = cdiff[8] ? 8'(-cdiff) : cdiff[7:0];
  assign bt    = lower ? blend_r : blend_r - AMBER_AT;
  assign bspan = lower ? AMBER_SPAN : RED_SPAN;
  assign after_blend = (op_r == OP_UPDATE) ? J_AVG : J_FIN;
  assign ovr_clamp = (item_r.override_value > 16'(RATIO_FULL)) ? 16'(RATIO_FULL)
                                                             : item_r.override_value;

  // One shared multiplier feeds the divider numerator.
  always_comb begin
    unique case (job_r)
      J_GLIDE: begin
        mul_a = 32'(gmag);  mul_b = 14'(elapsed[EW-1:0]);
        kbits = K_GLIDE;    den   = 15'(GLIDE_MS);
      end
      J_RATIO: begin
        mul_a = 32'(item_r.spd_kmh);  mul_b = RATIO_FULL;
        kbits = K_RATIO;              den   = 15'(mx);
      end
      J_AVG: begin
        mul_a = 32'(item_r.average_kph10);  mul_b = AVG_SCALE;
        kbits = K_AVG;                      den   = 15'(mx);
      end
      J_ODO: begin
        mul_a = item_r.odo_dist;  mul_b = MILE_NUM;
        kbits = K_ODO;            den   = MILE_DEN;
      end
      default: begin
        mul_a = 32'(cmag);  mul_b = bt;
        kbits = K_CH;       den   = bspan;
      end
    endcase
  end
  assign prod = 46'(mul_a) * 46'(mul_b);

  // restoring divide step: one quotient bit per cycle
  assign trial = {rem_r, num_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    ob = '0;
    ob.arc_ratio     = arc_now_r;
    ob.arc_rgb       = colour_r;
    ob.peak_arc      = peak_r;
    ob.peak_rgb      = peak_col_r;
    ob.avg_arc       = avg_r;
    ob.speed_ok      = spd_ok_r;
    ob.odo_status    = odo_st_r;
    ob.odo_value     = odo_val_r;
    ob.shows_miles   = miles_r;
    ob.clock_ok      = clk_ok_r;
    ob.shown_hour    = hour_r;
    ob.shown_minute  = min_r;
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;      job_r <= J_GLIDE;    cnt_r <= '0;
      mx_r <= MAX_DEF;      op_r <= OP_UPDATE;   neg_r <= 1'b0;
      arc_now_r <= '0;      arc_start_r <= '0;   arc_goal_r <= '0;
      move_r <= '0;         colour_r <= GREY_RGB;
      ovr_r <= 1'b0;        peak_r <= '0;        peak_col_r <= '0;
      gen_r <= '0;          spd_ok_r <= 1'b0;    sess_r <= 1'b0;
      clk_ok_r <= 1'b0;     miles_r <= 1'b0;     odo_st_r <= ODO_SHOWN;
      odo_val_r <= '0;      avg_r <= '0;         hour_r <= '0;
      min_r <= '0;          blend_r <= '0;       out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wen) mx_r <= cfg_wdata;
      // drop the beat once taken, unless the last step reloads it this cycle
      if (out_tvalid_r && out_tready && st_r != ST_DONE) out_tvalid_r <= 1'b0;

      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            item_r <= in_beat;
            op_r   <= in_tuser;
            priority case (in_tuser)
              OP_UPDATE: begin
                ovr_r <= 1'b0;
                // new session or lost session: drop the peak
                if (gen_r != in_beat.session_id || !in_beat.valid_flags[2]) begin
                  peak_r     <= '0;
                  peak_col_r <= BLUE_RGB;
                  gen_r      <= in_beat.session_id;
                end
                job_r <= J_GLIDE;
                st_r  <= ST_SETUP;
              end
              OP_OVERRIDE: begin
                ovr_r <= 1'b0;    // marks the force step as still pending
                job_r <= J_CH0;   // clamp in setup, then run the blend
                st_r  <= ST_SETUP;
              end
              OP_RECORD: begin
                if (sess_r && spd_ok_r && !ovr_r && arc_now_r >= peak_r) begin
                  peak_r     <= arc_now_r;
                  peak_col_r <= colour_r;
                end
                st_r <= ST_DONE;
              end
              default: st_r <= ST_DONE;
            endcase
          end
        end

        ST_SETUP: begin
          // override: force the arc once before its blend runs
          if (op_r == OP_OVERRIDE && job_r == J_CH0 && !ovr_r) begin
            arc_now_r   <= ovr_clamp[13:0];
            arc_start_r <= ovr_clamp[13:0];
            arc_goal_r  <= ovr_clamp[13:0];
            blend_r     <= ovr_clamp[13:0];
            move_r      <= item_r.now_ms;
            ovr_r       <= 1'b1;
          end else begin
            // load the divider; arms that need no divide stay in setup, and J_FIN goes to done
            num_r <= prod << (6'(DIV_NW) - kbits);
            rem_r <= '0;
            den_r <= den;
            cnt_r <= kbits;
            unique case (job_r)
              J_GLIDE: begin
                neg_r <= gdiff[14];
                if (elapsed >= 32'(GLIDE_MS)) begin
                  arc_now_r <= arc_goal_r;
                  job_r     <= J_RATIO;
                end else begin
                  st_r <= ST_DIV;
                end
              end
              J_RATIO: begin
                if (!item_r.valid_flags[0]) begin
                  // stale speed: freeze where the arc is
                  arc_start_r <= arc_now_r;
                  arc_goal_r  <= arc_now_r;
                  move_r      <= item_r.now_ms;
                  colour_r    <= GREY_RGB;
                  job_r       <= J_AVG;
                end else if (item_r.spd_kmh >= 16'(mx)) begin
                  if (arc_goal_r != RATIO_FULL) begin
                    arc_start_r <= arc_now_r;
                    arc_goal_r  <= RATIO_FULL;
                    move_r      <= item_r.now_ms;
                  end
                  blend_r <= arc_now_r;
                  job_r   <= J_CH0;
                end else begin
                  st_r <= ST_DIV;
                end
              end
              J_AVG: begin
                spd_ok_r <= item_r.valid_flags[0];
                sess_r   <= item_r.valid_flags[2];
                miles_r  <= item_r.units_miles;
                if (item_r.valid_flags[3] && item_r.clock_hour < 8'd24 &&
                    item_r.clock_minute < 8'd60) begin
                  clk_ok_r <= 1'b1;
                  hour_r   <= item_r.clock_hour[4:0];
                  min_r    <= item_r.clock_minute[5:0];
                end else begin
                  clk_ok_r <= 1'b0;
                  hour_r   <= '0;
                  min_r    <= '0;
                end
                if (item_r.average_kph10 >= 16'(13'(mx) * 13'd10)) begin
                  avg_r <= RATIO_FULL;
                  job_r <= J_ODO;
                end else begin
                  st_r <= ST_DIV;
                end
              end
              J_ODO: begin
                if (!item_r.valid_flags[1]) begin
                  odo_st_r  <= ODO_UNKNOWN;
                  odo_val_r <= '0;
                  job_r     <= J_FIN;
                end else if (!item_r.units_miles) begin
                  if (item_r.odo_dist > ODO_LIMIT) begin
                    odo_st_r  <= ODO_OVER;
                    odo_val_r <= '0;
                  end else begin
                    odo_st_r  <= ODO_SHOWN;
                    odo_val_r <= item_r.odo_dist[19:0];
                  end
                  job_r <= J_FIN;
                end else begin
                  st_r <= ST_DIV;
                end
              end
              J_CH0, J_CH1, J_CH2: begin
                neg_r <= cdiff[8];
                if (blend_r >= RED_AT) begin
                  colour_r <= RED_RGB;
                  job_r    <= after_blend;
                end else begin
                  st_r <= ST_DIV;
                end
              end
              default: st_r <= ST_DONE;   // J_FIN
            endcase
          end
        end

        ST_DIV: begin
          rem_r <= ge ? 15'(trial - {1'b0, den_r}) : trial[14:0];
          num_r <= {num_r[DIV_NW-2:0], ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) st_r <= ST_APPLY;
        end

        ST_APPLY: begin
          st_r <= ST_SETUP;
          unique case (job_r)
            J_GLIDE: begin
              arc_now_r <= neg_r ? arc_start_r - num_r[13:0] : arc_start_r + num_r[13:0];
              job_r     <= J_RATIO;
            end
            J_RATIO: begin
              if (arc_goal_r != num_r[13:0]) begin
                arc_start_r <= arc_now_r;
                arc_goal_r  <= num_r[13:0];
                move_r      <= item_r.now_ms;
              end
              blend_r <= arc_now_r;
              job_r   <= J_CH0;
            end
            J_AVG: begin
              avg_r <= num_r[13:0];
              job_r <= J_ODO;
            end
            J_ODO: begin
              if (num_r[31:0] > ODO_LIMIT) begin
                odo_st_r  <= ODO_OVER;
                odo_val_r <= '0;
              end else begin
                odo_st_r  <= ODO_SHOWN;
                odo_val_r <= num_r[19:0];
              end
              job_r <= J_FIN;
            end
            default: begin
              colour_r[{ch, 3'b000} +: 8] <= neg_r ? ca - num_r[7:0] : ca + num_r[7:0];
              job_r <= (job_r == J_CH2) ? after_blend : job_r + 3'd1;
            end
          endcase
        end

        ST_DONE: begin
          // hand the snapshot to the output register once it is empty or being taken
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= OUT_W'(ob);
            out_tvalid_r <= 1'b1;
            st_r         <= ST_IDLE;
          end
        end

        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sga_checker.sv
`include "speed_gauge_arc_smoother_defines.svh"

module sga_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic [sga_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready
);
  import sga_pkg::*;

  out_beat_t ob;
  logic      ratios_ok;
  logic      odo_code_ok;

  assign ob = out_beat_t'(out_tdata);
  assign ratios_ok = ob.arc_ratio <= RATIO_FULL && ob.peak_arc <= RATIO_FULL &&
                     ob.avg_arc <= RATIO_FULL;
  assign odo_code_ok = ob.odo_status == ODO_UNKNOWN || ob.odo_status == ODO_OVER;

  `SGA_NEXT_RST(a_rst_quiet, !rst_n, !out_tvalid)
  `SGA_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SGA_IMPLY(a_ratio_range, out_tvalid, ratios_ok)
  `SGA_IMPLY(a_odo_blank, out_tvalid && ob.odo_status != ODO_SHOWN, ob.odo_value == 20'd0 && odo_code_ok)
  `SGA_IMPLY(a_clock_blank, out_tvalid && !ob.clock_ok, ob.shown_hour == 5'd0 && ob.shown_minute == 6'd0)

endmodule

bind speed_gauge_arc_smoother sga_checker u_sga_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
